/* rtl/core/tapwf_pkg.sv */
// tapwf_pkg: shared types and constants of the tunable allpass filter.
// Used by tapwf_div, tapwf_mul and tunable_allpass_with_feedback; no dependencies.
package tapwf_pkg;

  localparam int FREQ_W  = 17;  // freq_hz, whole Hz
  localparam int RATE_W  = 18;  // sample_rate, Hz
  localparam int COEF_W  = 18;  // a0, signed Q2.16
  localparam int FRAC_W  = 16;  // fraction bits of omega and a0
  localparam int NUM_W   = 35;  // freq_hz * pi in Q16
  localparam int DIV_W   = 19;  // divisor and partial remainder
  localparam int QUO_W   = 18;  // quotient register
  localparam int STEP_W  = 5;   // divider step counter
  localparam int CFG_AW  = 3;   // APB byte address
  localparam int CFG_DW  = 32;  // APB data

  localparam logic [RATE_W-1:0] PI_Q16      = 18'd205887;  // round(pi * 2^16)
  localparam logic [DIV_W-1:0]  ONE_Q16     = 19'd65536;
  localparam logic [QUO_W-1:0]  OMEGA_MAX   = 18'h3FFFF;
  localparam logic [RATE_W-1:0] RATE_RESET  = 18'd44100;
  localparam logic [STEP_W-1:0] OMEGA_STEPS = 5'd18;
  localparam logic [STEP_W-1:0] COEF_STEPS  = 5'd16;

  // Register index, taken from paddr[2]
  localparam logic REG_SAMPLE_RATE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_OM,
    S_MUL_FB,
    S_FED,
    S_DIV_OM,
    S_COEF,
    S_DIV_A0,
    S_MUL_Y,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem0;     // initial partial remainder, below divisor
    logic [QUO_W-1:0]  bits;     // dividend bits shifted in, MSB first
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/core/tunable_allpass_with_feedback.sv */
// tunable_allpass_with_feedback: first-order allpass with output feedback, fixed point.
// Depends on tapwf_pkg, tapwf_mul (shared multiplier) and tapwf_div (serial divider).
//
// Usage:
//   in channel : one beat per audio sample, carrying sample_in, freq_hz and
//                feedback_gain. in_tready is high only while the sequencer idles.
//   out channel: one beat per accepted input, carrying sample_out. The result
//                sits in an output register, so a new input is taken while an
//                old result still waits for out_tready.
//   cfg port   : APB, sample_rate at byte address 0; write it only while idle.
// Timing: when omega saturates the omega division is skipped. A new beat is
//   taken in the cycle after the result is loaded. The two serial divisions
//   (18 and 16 steps through the one shared divider) set the time per sample.
// Reset: sample_rate returns to 44100, filter history (previous output and
//   previous fed input) clears to zero, no result is pending.
// Stall: a finished result holds in the sequencer's last step until the
//   output register is free; the filter history updates only then.
module tunable_allpass_with_feedback import tapwf_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  localparam int InDataW  = ((2 * SAMPLE_BITS + FREQ_W + 7) / 8) * 8,
  localparam int OutDataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: sample_in, freq_hz, feedback_gain (from bit 0 up)
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // out_tdata: sample_out (from bit 0 up)
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int SB   = SAMPLE_BITS;
  localparam int MulW = (SB + 1 > DIV_W) ? SB + 1 : DIV_W;
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] A0_ONE     = signed'(COEF_W'(ONE_Q16));
  localparam logic signed [COEF_W-1:0] A0_NEG_ONE = -A0_ONE;

  seq_state_t state_r, state_nxt;

  // Configuration and filter history
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic signed [SB-1:0] prev_out_r, prev_out_nxt;
  logic signed [SB-1:0] prev_fed_r, prev_fed_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Per-sample working registers
  logic signed [SB-1:0]     x_r, x_nxt;
  logic [FREQ_W-1:0]        freq_r, freq_nxt;
  logic signed [SB-1:0]     gain_r, gain_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic signed [SB-1:0]     fed_r, fed_nxt;
  logic [QUO_W-1:0]         omega_r, omega_nxt;
  logic                     coef_neg_r, coef_neg_nxt;
  logic signed [COEF_W-1:0] a0_r, a0_nxt;
  logic [OutDataW-1:0]      out_data_r, out_data_nxt;

  // Shared units
  logic                      mul_en;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [2*MulW-1:0]  prod;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // Datapath terms
  logic                      in_beat;
  logic                      cfg_wr;
  logic                      omega_ovf;
  logic                      out_free;
  logic signed [2*MulW-1:0]  fb_full;
  logic signed [SB+1:0]      fed_wide;
  logic signed [SB:0]        diff;
  logic [DIV_W-1:0]          om_ext;
  logic [DIV_W-1:0]          coef_mag;
  logic [COEF_W-1:0]         q_ext;
  logic signed [2*MulW-1:0]  prod_sh;
  logic signed [SB+1:0]      y_wide;
  logic signed [SB-1:0]      y_sat;

  tapwf_mul #(.MulW(MulW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  tapwf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SAMPLE_RATE) ? CFG_DW'(rate_r) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Combinational datapath terms
  always_comb begin
    // feedback term, floor of (prev_output * gain) / 2^(SB-1)
    fb_full  = prod >>> (SB - 1);
    fed_wide = (SB+2)'(x_r) - (SB+2)'(signed'(fb_full[SB:0]));
    diff     = (SB+1)'(fed_r) - (SB+1)'(prev_out_r);
    // quotient cannot fit 18 bits when num / 2^18 >= rate (covers zero rate too)
    omega_ovf = {1'b0, num_r[NUM_W-1:QUO_W]} >= rate_r;
    om_ext    = {1'b0, omega_r};
    coef_mag  = (omega_r[QUO_W-1:FRAC_W] == '0) ? (ONE_Q16 - om_ext) : (om_ext - ONE_Q16);
    q_ext     = {{(COEF_W-FRAC_W){1'b0}}, div_rsp.quot[FRAC_W-1:0]};
    prod_sh   = prod >>> FRAC_W;
    y_wide    = signed'(prod_sh[SB+1:0]) + (SB+2)'(prev_fed_r);
    if (y_wide > (SB+2)'(SMAX)) begin
      y_sat = SMAX;
    end else if (y_wide < (SB+2)'(SMIN)) begin
      y_sat = SMIN;
    end else begin
      y_sat = y_wide[SB-1:0];
    end
    out_free = !out_valid_r || out_tready;
  end

  // Sequencer: next state, unit controls and register updates
  always_comb begin
    state_nxt     = state_r;
    rate_nxt      = rate_r;
    prev_out_nxt  = prev_out_r;
    prev_fed_nxt  = prev_fed_r;
    out_valid_nxt = out_valid_r;
    x_nxt         = x_r;
    freq_nxt      = freq_r;
    gain_nxt      = gain_r;
    num_nxt       = num_r;
    fed_nxt       = fed_r;
    omega_nxt     = omega_r;
    coef_neg_nxt  = coef_neg_r;
    a0_nxt        = a0_r;
    out_data_nxt  = out_data_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    if (cfg_wr && cfg_paddr[2] == REG_SAMPLE_RATE) begin
      rate_nxt = cfg_pwdata[RATE_W-1:0];
    end
    // drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          x_nxt     = in_tdata[SB-1:0];
          freq_nxt  = in_tdata[SB+FREQ_W-1:SB];
          gain_nxt  = in_tdata[2*SB+FREQ_W-1:SB+FREQ_W];
          state_nxt = S_MUL_OM;
        end
      end
      S_MUL_OM: begin
        mul_en    = 1'b1;
        mul_a     = MulW'(freq_r);
        mul_b     = MulW'(PI_Q16);
        state_nxt = S_MUL_FB;
      end
      S_MUL_FB: begin
        num_nxt   = prod[NUM_W-1:0];
        mul_en    = 1'b1;
        mul_a     = MulW'(prev_out_r);
        mul_b     = MulW'(gain_r);
        state_nxt = S_FED;
      end
      S_FED: begin
        if (fed_wide > (SB+2)'(SMAX)) begin
          fed_nxt = SMAX;
        end else if (fed_wide < (SB+2)'(SMIN)) begin
          fed_nxt = SMIN;
        end else begin
          fed_nxt = fed_wide[SB-1:0];
        end
        if (omega_ovf) begin
          omega_nxt = OMEGA_MAX;
          state_nxt = S_COEF;
        end else begin
          // omega = num / rate, high bits seed the remainder
          div_req.start   = 1'b1;
          div_req.rem0    = DIV_W'(num_r[NUM_W-1:QUO_W]);
          div_req.bits    = num_r[QUO_W-1:0];
          div_req.divisor = DIV_W'(rate_r);
          div_req.steps   = OMEGA_STEPS;
          state_nxt       = S_DIV_OM;
        end
      end
      S_DIV_OM: begin
        if (div_rsp.done) begin
          omega_nxt = div_rsp.quot;
          state_nxt = S_COEF;
        end
      end
      S_COEF: begin
        // |a0| = |omega - 1| * 2^16 / (omega + 1), sign applied afterwards
        coef_neg_nxt    = (omega_r[QUO_W-1:FRAC_W] == '0);
        div_req.start   = 1'b1;
        div_req.rem0    = coef_mag;
        div_req.bits    = '0;
        div_req.divisor = om_ext + ONE_Q16;
        div_req.steps   = COEF_STEPS;
        state_nxt       = S_DIV_A0;
      end
      S_DIV_A0: begin
        if (div_rsp.done) begin
          // zero omega gives exactly minus one, beyond the 16-bit quotient
          if (omega_r == '0) begin
            a0_nxt = A0_NEG_ONE;
          end else begin
            a0_nxt = coef_neg_r ? -signed'(q_ext) : signed'(q_ext);
          end
          state_nxt = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        mul_en    = 1'b1;
        mul_a     = MulW'(a0_r);
        mul_b     = MulW'(diff);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold here until the output register is free
        if (out_free) begin
          out_data_nxt  = OutDataW'(unsigned'(y_sat));
          out_valid_nxt = 1'b1;
          prev_out_nxt  = y_sat;
          prev_fed_nxt  = fed_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RESET;
      prev_out_r  <= '0;
      prev_fed_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      prev_out_r  <= prev_out_nxt;
      prev_fed_r  <= prev_fed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    freq_r     <= freq_nxt;
    gain_r     <= gain_nxt;
    num_r      <= num_nxt;
    fed_r      <= fed_nxt;
    omega_r    <= omega_nxt;
    coef_neg_r <= coef_neg_nxt;
    a0_r       <= a0_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted beat keeps the block busy on the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input taken again right after a beat");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV_OM || state_r == S_DIV_A0))
    else $error("divider finished outside a division step");

  // The allpass coefficient stays within [-1, 1).
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL_Y |-> (a0_r >= A0_NEG_ONE && a0_r < A0_ONE))
    else $error("allpass coefficient out of range");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending output beat overwritten");

endmodule

/* rtl/core/tapwf_div.sv */
// tapwf_div: restoring divider, one quotient bit per cycle.
// Depends on tapwf_pkg (div_req_t, div_rsp_t, widths).
module tapwf_div import tapwf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0]  sh_r, sh_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  always_comb begin
    trial    = {rem_r, sh_r[QUO_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem0;
      den_nxt  = req.divisor;
      sh_nxt   = req.bits;
    end else if (busy_r) begin
      // shift the next dividend bit in, subtract when it fits
      rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      sh_nxt  = {sh_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = sh_r;

endmodule

/* rtl/core/tapwf_mul.sv */
// tapwf_mul: registered signed multiplier shared by all products of the filter.
// Depends on tapwf_pkg only through the common import convention.
module tapwf_mul import tapwf_pkg::*; #(
  parameter int MulW = 19
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [MulW-1:0] a,
  input  logic signed [MulW-1:0] b,
  output logic signed [2*MulW-1:0] p
);

  logic signed [2*MulW-1:0] p_r, p_nxt;

  always_comb begin
    p_nxt = en ? a * b : p_r;
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

/* tb/tb_tunable_allpass_with_feedback.sv */
// tb_tunable_allpass_with_feedback: self-checking bench for the fixed-point tunable allpass.
// Needs tapwf_pkg and tunable_allpass_with_feedback; predicts every output beat and
// compares it in order, over several sample rates and handshake stall patterns.
module tb_tunable_allpass_with_feedback;
  timeunit 1ns;
  timeprecision 1ps;

  import tapwf_pkg::*;

  localparam int SampleBits = 16;
  localparam int InW  = ((2 * SampleBits + FREQ_W + 7) / 8) * 8;
  localparam int OutW = ((SampleBits + 7) / 8) * 8;

  // Register map: index from paddr[2], word aligned.
  localparam logic [CFG_AW-1:0] ADDR_SAMPLE_RATE = {REG_SAMPLE_RATE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED    = {~REG_SAMPLE_RATE, 2'b00};

  localparam int  MAX_GAP        = 60;    // longest sender gap, cycles
  localparam int  HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int  WATCHDOG_LIMIT = 3000;  // cycles with no beat while busy
  localparam int  END_WAIT       = 60;    // idle wait after the last drain
  localparam int  MAX_REPORTS    = 10;
  localparam longint Q16_ONE     = 65536;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [InW-1:0]   in_tdata;   // sample_in, freq_hz, feedback_gain (from bit 0 up)
  logic             out_tvalid;
  logic             out_tready;
  logic [OutW-1:0]  out_tdata;  // sample_out (from bit 0 up)
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic             cfg_pready;

  // Predictor state: the register copy and the two history words.
  logic [RATE_W-1:0] rate_q = RATE_RESET;
  longint            hist_out = 0;
  longint            hist_fed = 0;

  logic [SampleBits-1:0] expected_out_q[$];

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int rate_settings = 0;

  tunable_allpass_with_feedback #(.SAMPLE_BITS(SampleBits)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic longint sat_sample(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the filter by one sample and return the expected output word.
  function automatic logic [SampleBits-1:0] allpass_step(input logic signed [15:0] x,
                                                         input logic [FREQ_W-1:0] f,
                                                         input logic signed [15:0] g);
    longint omega, a0, fb, fed, diff, y;
    // Zero sample rate: no division, omega pins at full scale.
    if (rate_q == '0) begin
      omega = longint'(OMEGA_MAX);
    end else begin
      omega = (longint'(f) * longint'(PI_Q16)) / longint'(rate_q);
      if (omega > longint'(OMEGA_MAX)) omega = longint'(OMEGA_MAX);
    end
    // Signed division truncates toward zero, as the coefficient needs.
    a0   = ((omega - Q16_ONE) * Q16_ONE) / (omega + Q16_ONE);
    // Arithmetic shifts of signed values floor toward minus infinity.
    fb   = (hist_out * longint'(g)) >>> (SampleBits - 1);
    fed  = sat_sample(longint'(x) - fb);
    diff = fed - hist_out;
    y    = sat_sample(((a0 * diff) >>> 16) + hist_fed);
    hist_out = y;
    hist_fed = fed;
    return y[SampleBits-1:0];
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
  endfunction

  // ------------------------------------------------------------------
  // Result checker: compare each output beat with the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_out_q.size() == 0) begin
        note_mismatch("output beat with nothing pending", '0, out_tdata);
      end else begin
        if (out_tdata[SampleBits-1:0] !== expected_out_q[0])
          note_mismatch("sample_out", expected_out_q[0], out_tdata[SampleBits-1:0]);
        void'(expected_out_q.pop_front());
      end
    end
  end

  // Watchdog: count busy cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (expected_out_q.size() == 0 && !in_tvalid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               idle_cycles, expected_out_q.size());
      $display("tb_tunable_allpass_with_feedback NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Shared drivers
  // ------------------------------------------------------------------
  // Offer one sample beat, optionally after a random gap, and predict it once taken.
  task automatic send_sample(input logic signed [15:0] x, input logic [FREQ_W-1:0] f,
                             input logic signed [15:0] g);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      gap = $urandom_range(1, MAX_GAP);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InW'({g, f, x});
    do @(posedge clk); while (!in_tready);
    expected_out_q.push_back(allpass_step(x, f, g));
    items_sent++;
  endtask

  // Drop valid and hold until every predicted output has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: setup then access; track writes, check reads of the rate.
  task automatic cfg_access(input bit is_write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[2] == REG_SAMPLE_RATE) begin
      if (is_write) begin
        rate_q = data[RATE_W-1:0];
        rate_settings++;
      end else if (cfg_prdata !== CFG_DW'(rate_q)) begin
        note_mismatch("sample_rate readback", CFG_DW'(rate_q), cfg_prdata);
      end
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Audio-like sample with a mix of quiet, loud and full-scale content.
  task automatic send_random_sample();
    logic signed [15:0] x, g;
    logic [FREQ_W-1:0]  f;
    int pick, top;
    pick = $urandom_range(0, 99);
    if (pick < 8)       x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else if (pick < 40) x = 16'($urandom_range(0, 4000)) - 16'sd2000;
    else                x = 16'($urandom);
    // Mostly below half the rate; sometimes anywhere the field allows.
    top  = (rate_q == '0) ? 96000 : ((rate_q / 2 > 96000) ? 96000 : rate_q / 2);
    pick = $urandom_range(0, 99);
    if (pick < 75)      f = FREQ_W'($urandom_range(0, top));
    else if (pick < 85) f = FREQ_W'($urandom_range(0, 96000));
    else                f = FREQ_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4)       g = 16'sh7FFF;
    else if (pick < 8)  g = 16'sh8000;
    else if (pick < 12) g = 16'sh0000;
    else if (pick < 60) g = 16'($urandom_range(0, 32767)) - 16'sd16384;
    else                g = 16'($urandom);
    send_sample(x, f, g);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Default rate after reset: read it back, then walk the field extremes.
  task automatic test_reset_defaults();
    cfg_access(1'b0, ADDR_SAMPLE_RATE, '0);
    send_sample(16'sh0000, 17'd0,      16'sh0000);
    send_sample(16'sh7FFF, 17'd0,      16'sh0000);
    send_sample(16'sh8000, 17'd22050,  16'sh0000);
    send_sample(16'sh7FFF, 17'd1000,   16'sh7FFF);
    send_sample(16'sh8000, 17'd1000,   16'sh8000);
    // Frequency far above half the rate: omega clips at full scale.
    send_sample(16'sd12345, 17'h1FFFF, 16'sd16384);
    send_sample(-16'sd1,    17'd96000, -16'sd16384);
    drain_results();
  endtask

  // Rate extremes, the zero rate, masking of wide writes, and an unmapped write.
  task automatic test_rate_extremes();
    cfg_access(1'b1, ADDR_SAMPLE_RATE, 32'd8000);
    cfg_access(1'b0, ADDR_SAMPLE_RATE, '0);
    send_sample(16'sh7FFF, 17'd4000,  16'sh8000);
    send_sample(16'sh8000, 17'd96000, 16'sh7FFF);
    send_sample(16'sd100,  17'd1,     16'sh0000);
    drain_results();
    cfg_access(1'b1, ADDR_SAMPLE_RATE, 32'd192000);
    send_sample(16'sh8000, 17'd96000, 16'sh7FFF);
    send_sample(16'sh7FFF, 17'd1,     16'sh8000);
    send_sample(16'sh0000, 17'h1FFFF, 16'sh4000);
    drain_results();
    // Upper data bits fall outside the 18-bit register: rate becomes zero.
    cfg_access(1'b1, ADDR_SAMPLE_RATE, 32'hFFFC_0000);
    cfg_access(1'b0, ADDR_SAMPLE_RATE, '0);
    send_sample(16'sh7FFF, 17'd0,     16'sh7FFF);
    send_sample(16'sh8000, 17'h1FFFF, 16'sh8000);
    send_sample(16'sd5000, 17'd48000, 16'sh0000);
    drain_results();
    cfg_access(1'b1, ADDR_SAMPLE_RATE, 32'hFFFF_FFFF);
    cfg_access(1'b0, ADDR_SAMPLE_RATE, '0);
    send_sample(16'sh7FFF, 17'h1FFFF, 16'sh0000);
    send_sample(16'sh8000, 17'd1,     16'sh7FFF);
    drain_results();
    // A write past the register list must leave the rate alone.
    cfg_access(1'b1, ADDR_UNMAPPED, $urandom);
    cfg_access(1'b0, ADDR_SAMPLE_RATE, '0);
    send_sample(-16'sd20000, 17'd30000, -16'sd30000);
    drain_results();
  endtask

  // One random phase: set the rate while idle, then stream with the given stalls.
  task automatic test_random_phase(input logic [CFG_DW-1:0] rate, input int snd_pct,
                                   input int rcv_pct, input int n);
    drain_results();
    cfg_access(1'b1, ADDR_SAMPLE_RATE, rate);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (n) send_random_sample();
  endtask

  // Hold the receiver off so the block backs up, then pause the sender until empty.
  task automatic test_fill_and_drain();
    drain_results();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_random_sample();
    drain_results();
    repeat (12) send_random_sample();
    drain_results();
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_rate_extremes();
    test_random_phase(32'd44100,  0,  0,  110);
    test_random_phase(32'd48000,  79, 0,  110);
    test_random_phase(32'd8000,   0,  79, 110);
    test_random_phase(32'd192000, 8,  8,  110);
    test_fill_and_drain();
    test_random_phase(CFG_DW'($urandom_range(0, 262143)), 0, 0, 80);
    test_random_phase(32'd262143, 79, 79, 60);
    test_random_phase(32'd0,      8,  8,  40);

    drain_results();
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d samples and %0d output beats over %0d rate settings,",
             items_sent, results_seen, rate_settings);
    $display("including zero and full-scale rates, clipped omega and long back-pressure");
    if (errors == 0 && expected_out_q.size() == 0) begin
      $display("tb_tunable_allpass_with_feedback OK");
    end else begin
      $display("%0d mismatches, %0d outputs missing", errors, expected_out_q.size());
      $display("tb_tunable_allpass_with_feedback NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tapwf_pkg.sv
rtl/core/tapwf_div.sv
rtl/core/tapwf_mul.sv
rtl/core/tunable_allpass_with_feedback.sv
tb/tb_tunable_allpass_with_feedback.sv
